### src/cel_pkg.sv
`default_nettype none

package cel_pkg;

    localparam int PROB_W     = 17;
    localparam int VAL_W      = 40;
    localparam int SUM_W      = 48;
    localparam int EPS_W      = 15;
    localparam int CNT_W      = 16;
    localparam int CFG_W      = 16;
    localparam int LOG_ROUNDS = 24;
    localparam int DIV_W      = 49;
    localparam int DVS_W      = 33;
    localparam int STEP_W     = 6;

    localparam logic [31:0]       LN2_Q32     = 32'd2977044472;
    localparam logic [PROB_W-1:0] ONE_Q16     = 17'd65536;
    localparam logic [SUM_W-1:0]  SUM_MAX     = 48'hFFFF_FFFF_FFFF;
    localparam logic [VAL_W-1:0]  VAL_POS_MAX = 40'h7F_FFFF_FFFF;
    localparam logic [VAL_W-1:0]  VAL_NEG_MAG = 40'h80_0000_0000;

    localparam logic REG_EPSILON = 1'b0;
    localparam logic REG_BATCH   = 1'b1;

    localparam logic FUNC_LOSS = 1'b0;
    localparam logic FUNC_GRAD = 1'b1;
    localparam logic KIND_LOSS = 1'b0;
    localparam logic KIND_GRAD = 1'b1;

    typedef struct packed {
        logic              func;
        logic [PROB_W-1:0] prediction;
        logic [PROB_W-1:0] target;
        logic              last;
    } item_t;

    typedef struct packed {
        logic                    kind;
        logic signed [VAL_W-1:0] value;
        logic                    saturated;
    } result_t;

    typedef struct packed {
        logic load;
        logic prep;
        logic log_step;
        logic ln_mul;
        logic term_mul;
        logic accum;
        logic grad_mul;
        logic div_init;
        logic div_step;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic func;
        logic tgt_zero;
        logic last;
    } status_t;

endpackage

`default_nettype wire

### src/cel_dpath.sv
`default_nettype none

module cel_dpath #(
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      wr_en,
    input  wire logic                      wr_index,
    input  wire logic [cel_pkg::CFG_W-1:0] wr_data,
    input  wire cel_pkg::item_t            item,
    input  wire cel_pkg::cmd_t             cmd,
    output cel_pkg::status_t               status,
    output cel_pkg::result_t               result
);

    localparam int SH = 40 - FRACTION_BITS;

    logic [cel_pkg::EPS_W-1:0]  eps_reg;
    logic [cel_pkg::CNT_W-1:0]  n_reg;
    logic                       func_reg;
    logic [cel_pkg::PROB_W-1:0] pred_reg;
    logic [cel_pkg::PROB_W-1:0] tgt_reg;
    logic                       last_reg;
    logic [31:0]                x_reg;
    logic [3:0]                 k_reg;
    logic [23:0]                frac_reg;
    logic [27:0]                ln_reg;
    logic [cel_pkg::SUM_W-1:0]  term_reg;
    logic [cel_pkg::SUM_W-1:0]  sum_reg;
    logic [cel_pkg::DVS_W-1:0]  d_reg;
    logic [cel_pkg::DIV_W-1:0]  dvd_reg;
    logic [cel_pkg::DVS_W:0]    rem_reg;
    logic [cel_pkg::DVS_W-1:0]  dvs_reg;
    logic                       sumsat_reg;
    cel_pkg::result_t           result_reg;

    logic [cel_pkg::PROB_W-1:0] eps17;
    logic [cel_pkg::CNT_W-1:0]  n_eff;
    logic [cel_pkg::PROB_W-1:0] p_lo;
    logic [cel_pkg::PROB_W-1:0] p_loss;
    logic [15:0]                p16;
    logic [3:0]                 k;
    logic [31:0]                x_init;
    logic [63:0]                sq;
    logic [31:0]                sq_sh;
    logic [28:0]                mag;
    logic [61:0]                ln_rnd;
    logic [44:0]                term_prod;
    logic [45:0]                term_rnd;
    logic [cel_pkg::SUM_W:0]    sum_add;
    logic [cel_pkg::PROB_W-1:0] p_grad;
    logic [cel_pkg::DVS_W:0]    rem_sh;
    logic                       ge;
    logic                       over;
    logic [cel_pkg::VAL_W-1:0]  q40;

    assign eps17  = (eps_reg == '0) ? 17'd1 : {2'b0, eps_reg};
    assign n_eff  = (n_reg == '0) ? 16'd1 : n_reg;
    assign p_lo   = (pred_reg < eps17) ? eps17 : pred_reg;
    assign p_loss = (p_lo > (cel_pkg::ONE_Q16 - eps17)) ? (cel_pkg::ONE_Q16 - eps17) : p_lo;
    assign p16    = p_loss[15:0];
    assign p_grad = (pred_reg < eps17) ? eps17 : pred_reg;

    // leading one of the clamped prediction
    always_comb
    begin
        k = '0;
        for (int i = 0; i < 16; i++)
        begin
            if (p16[i])
            begin
                k = 4'(i);
            end
        end
    end

    assign x_init    = {16'b0, p16} << (5'd30 - {1'b0, k});
    assign sq        = x_reg * x_reg;
    assign sq_sh     = sq[61:30];
    assign mag       = {5'(5'd16 - {1'b0, k_reg}), 24'b0} - {5'b0, frac_reg};
    assign ln_rnd    = {1'b0, 61'(mag) * 61'(cel_pkg::LN2_Q32)} + (62'd1 << 31);
    assign term_prod = tgt_reg * ln_reg;
    assign term_rnd  = {1'b0, term_prod} + (46'd1 << (SH - 1));
    assign sum_add   = {1'b0, sum_reg} + {1'b0, term_reg};
    assign rem_sh    = {rem_reg[cel_pkg::DVS_W-1:0], dvd_reg[cel_pkg::DIV_W-1]};
    assign ge        = rem_sh >= {1'b0, dvs_reg};

    always_comb
    begin
        if (func_reg == cel_pkg::FUNC_LOSS)
        begin
            over = dvd_reg > {9'b0, cel_pkg::VAL_POS_MAX};
            q40  = over ? cel_pkg::VAL_POS_MAX : dvd_reg[cel_pkg::VAL_W-1:0];
        end
        else
        begin
            over = dvd_reg > {9'b0, cel_pkg::VAL_NEG_MAG};
            q40  = over ? cel_pkg::VAL_NEG_MAG : dvd_reg[cel_pkg::VAL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg <= 15'd1;
            n_reg   <= 16'd1;
            sum_reg <= '0;
        end
        else
        begin
            if (wr_en && wr_index == cel_pkg::REG_EPSILON)
            begin
                eps_reg <= wr_data[cel_pkg::EPS_W-1:0];
            end
            if (wr_en && wr_index == cel_pkg::REG_BATCH)
            begin
                n_reg <= wr_data;
            end
            if (cmd.accum)
            begin
                sum_reg <= sum_add[cel_pkg::SUM_W] ? cel_pkg::SUM_MAX
                                                   : sum_add[cel_pkg::SUM_W-1:0];
            end
            else if (cmd.div_init && func_reg == cel_pkg::FUNC_LOSS)
            begin
                sum_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= item.func;
            pred_reg <= item.prediction;
            tgt_reg  <= item.target;
            last_reg <= item.last;
        end
        if (cmd.prep)
        begin
            x_reg    <= x_init;
            k_reg    <= k;
            frac_reg <= '0;
        end
        if (cmd.log_step)
        begin
            x_reg    <= sq_sh[31] ? (sq_sh >> 1) : sq_sh;
            frac_reg <= {frac_reg[22:0], sq_sh[31]};
        end
        if (cmd.ln_mul)
        begin
            ln_reg <= ln_rnd[59:32];
        end
        if (cmd.term_mul)
        begin
            term_reg <= 48'(term_rnd >> SH);
        end
        if (cmd.grad_mul)
        begin
            d_reg <= p_grad * n_eff;
        end
        if (cmd.div_init)
        begin
            rem_reg <= '0;
            if (func_reg == cel_pkg::FUNC_LOSS)
            begin
                dvd_reg    <= {1'b0, sum_reg} + {34'b0, n_eff[15:1]};
                dvs_reg    <= {17'b0, n_eff};
                sumsat_reg <= (sum_reg == cel_pkg::SUM_MAX);
            end
            else
            begin
                dvd_reg    <= (49'(tgt_reg) << FRACTION_BITS) + {17'b0, d_reg[32:1]};
                dvs_reg    <= d_reg;
                sumsat_reg <= 1'b0;
            end
        end
        if (cmd.div_step)
        begin
            rem_reg <= ge ? (rem_sh - {1'b0, dvs_reg}) : rem_sh;
            dvd_reg <= {dvd_reg[cel_pkg::DIV_W-2:0], ge};
        end
        if (cmd.emit)
        begin
            if (func_reg == cel_pkg::FUNC_LOSS)
            begin
                result_reg.kind      <= cel_pkg::KIND_LOSS;
                result_reg.value     <= q40;
                result_reg.saturated <= over | sumsat_reg;
            end
            else
            begin
                result_reg.kind      <= cel_pkg::KIND_GRAD;
                result_reg.value     <= 40'(~q40 + 40'd1);
                result_reg.saturated <= over;
            end
        end
    end

    assign status.func     = func_reg;
    assign status.tgt_zero = (tgt_reg == '0);
    assign status.last     = last_reg;
    assign result          = result_reg;

endmodule

`default_nettype wire

### src/cel_ctrl.sv
`default_nettype none

module cel_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_stall,
    output logic                  result_valid,
    input  wire logic             result_stall,
    input  wire cel_pkg::status_t status,
    output cel_pkg::cmd_t         cmd
);

    localparam int STEP_W = cel_pkg::STEP_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_PREP,
        S_LOG,
        S_LN,
        S_TERM,
        S_ACC,
        S_GMUL,
        S_DINIT,
        S_DIV,
        S_EMIT
    } state_t;

    state_t                      state_reg;
    logic [cel_pkg::STEP_W-1:0]  cnt_reg;
    logic                        out_valid_reg;
    logic                        room;

    assign room = !out_valid_reg || !result_stall;

    always_comb
    begin
        cmd          = '0;
        cmd.load     = (state_reg == S_IDLE) && item_valid;
        cmd.prep     = (state_reg == S_PREP);
        cmd.log_step = (state_reg == S_LOG);
        cmd.ln_mul   = (state_reg == S_LN);
        cmd.term_mul = (state_reg == S_TERM);
        cmd.accum    = (state_reg == S_ACC);
        cmd.grad_mul = (state_reg == S_GMUL);
        cmd.div_init = (state_reg == S_DINIT);
        cmd.div_step = (state_reg == S_DIV);
        cmd.emit     = (state_reg == S_EMIT) && room;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_EMIT && room)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (item_valid)
                    begin
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE:
                begin
                    if (status.func == cel_pkg::FUNC_GRAD)
                    begin
                        state_reg <= S_GMUL;
                    end
                    else if (!status.tgt_zero)
                    begin
                        state_reg <= S_PREP;
                    end
                    else
                    begin
                        state_reg <= status.last ? S_DINIT : S_IDLE;
                    end
                end
                S_PREP:
                begin
                    cnt_reg   <= STEP_W'(cel_pkg::LOG_ROUNDS - 1);
                    state_reg <= S_LOG;
                end
                S_LOG:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                    begin
                        state_reg <= S_LN;
                    end
                end
                S_LN:
                begin
                    state_reg <= S_TERM;
                end
                S_TERM:
                begin
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    state_reg <= status.last ? S_DINIT : S_IDLE;
                end
                S_GMUL:
                begin
                    state_reg <= S_DINIT;
                end
                S_DINIT:
                begin
                    cnt_reg   <= STEP_W'(cel_pkg::DIV_W - 1);
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                    begin
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (room)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = out_valid_reg;

endmodule

`default_nettype wire

### src/cross_entropy_loss_and_gradient.sv
// loss element, not last: ready for the next request after the 24-round log loop and accumulate
// last loss element: the result comes from the 49-step restoring divider
// gradient element: the result comes from the same divider; one request in flight at a time
// a waiting result sits in the output register while the next request is taken
// reset (async, active low) clears the loss sum, the controller and the output valid;
// epsilon and batch count return to 1
`default_nettype none

module cross_entropy_loss_and_gradient #(
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      item_valid,
    output logic                           item_stall,
    input  wire cel_pkg::item_t            item,
    output logic                           result_valid,
    input  wire logic                      result_stall,
    output cel_pkg::result_t               result,
    input  wire logic                      wr_en,
    input  wire logic                      wr_index,
    input  wire logic [cel_pkg::CFG_W-1:0] wr_data
);

    cel_pkg::cmd_t    cmd;
    cel_pkg::status_t status;

    cel_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .cmd          (cmd)
    );

    cel_dpath #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .item     (item),
        .cmd      (cmd),
        .status   (status),
        .result   (result)
    );

endmodule

`default_nettype wire

### src/cel_checker.sv
`default_nettype none

module cel_checker (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             item_valid,
    input wire logic             item_stall,
    input wire logic             result_valid,
    input wire logic             result_stall,
    input wire cel_pkg::result_t result
);

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed");

    // one request at a time
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("request taken while busy");

    a_grad_sign: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.kind == cel_pkg::KIND_GRAD
            |-> result.value[39] || result.value == '0)
        else $error("positive gradient");

    a_loss_sign: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.kind == cel_pkg::KIND_LOSS |-> !result.value[39])
        else $error("negative loss");

    a_reset: assert property (@(posedge clk) !rst_n |-> !result_valid)
        else $error("result valid in reset");

endmodule

bind cross_entropy_loss_and_gradient cel_checker u_cel_checker (.*);

`default_nettype wire

### sim/cross_entropy_loss_and_gradient_tb.sv
`default_nettype none

module cross_entropy_loss_and_gradient_tb;

    localparam int FRAC = 16;
    localparam int WATCHDOG_LIMIT = 20000;

    logic clk;
    logic rst_n;
    logic item_valid;
    logic item_stall;
    cel_pkg::item_t item;
    logic result_valid;
    logic result_stall;
    cel_pkg::result_t result;
    logic wr_en;
    logic wr_index;
    logic [cel_pkg::CFG_W-1:0] wr_data;

    cross_entropy_loss_and_gradient #(.FRACTION_BITS(FRAC)) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result),
        .wr_en(wr_en),
        .wr_index(wr_index),
        .wr_data(wr_data)
    );

    // shadow copy of the block's registers and loss sum
    logic [cel_pkg::EPS_W-1:0] eps_reg;
    logic [cel_pkg::CNT_W-1:0] n_reg;
    logic [cel_pkg::SUM_W-1:0] loss_acc;
    cel_pkg::result_t expected_results[$];
    int errors;
    int idle_cycles;
    bit hold_off;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // -ln(p/1.0) in Q.24, p in 1..65535
    function automatic logic [63:0] neg_ln(input logic [16:0] p);
        int k;
        logic [63:0] x;
        logic [63:0] frac;
        logic [63:0] mag;
        logic [95:0] prod;
        k = 0;
        frac = 0;
        while (k < 15 && (p >> (k + 1)) != 0)
            k++;
        x = 64'(p) << (30 - k);
        for (int i = 1; i <= 24; i++)
        begin
            x = (x * x) >> 30;
            if (x >= (64'd1 << 31))
            begin
                x = x >> 1;
                frac[24 - i] = 1'b1;
            end
        end
        mag = (64'(16 - k) << 24) - frac;
        prod = 96'(mag) * 96'(cel_pkg::LN2_Q32) + (96'd1 << 31);
        return 64'(prod >> 32);
    endfunction

    // updates the loss sum; returns 1 with a result where one is due
    function automatic bit predict_item(input cel_pkg::item_t it, output cel_pkg::result_t r);
        logic [63:0] e;
        logic [63:0] n;
        logic [63:0] p;
        logic [63:0] term;
        logic [63:0] q;
        logic [63:0] d;
        logic [63:0] mag;
        bit sat;
        e = (eps_reg == 0) ? 64'd1 : 64'(eps_reg);
        n = (n_reg == 0) ? 64'd1 : 64'(n_reg);
        r = '0;
        if (it.func == cel_pkg::FUNC_LOSS)
        begin
            if (it.target != 0)
            begin
                p = 64'(it.prediction);
                if (p < e)
                    p = e;
                if (p > 64'(cel_pkg::ONE_Q16) - e)
                    p = 64'(cel_pkg::ONE_Q16) - e;
                term = 64'(it.target) * neg_ln(17'(p));
                term = (term + (64'd1 << (40 - FRAC - 1))) >> (40 - FRAC);
                if (term > 64'(cel_pkg::SUM_MAX) - 64'(loss_acc))
                    loss_acc = cel_pkg::SUM_MAX;
                else
                    loss_acc = cel_pkg::SUM_W'(64'(loss_acc) + term);
            end
            if (!it.last)
                return 0;
            sat = (loss_acc == cel_pkg::SUM_MAX);
            q = (64'(loss_acc) + n / 2) / n;
            if (q > 64'(cel_pkg::VAL_POS_MAX))
            begin
                q = 64'(cel_pkg::VAL_POS_MAX);
                sat = 1'b1;
            end
            loss_acc = '0;
            r.kind = cel_pkg::KIND_LOSS;
            r.value = cel_pkg::VAL_W'(q);
            r.saturated = sat;
            return 1;
        end
        p = (64'(it.prediction) < e) ? e : 64'(it.prediction);
        d = p * n;
        mag = ((64'(it.target) << FRAC) + d / 2) / d;
        sat = 1'b0;
        if (mag > 64'(cel_pkg::VAL_NEG_MAG))
        begin
            mag = 64'(cel_pkg::VAL_NEG_MAG);
            sat = 1'b1;
        end
        r.kind = cel_pkg::KIND_GRAD;
        r.value = cel_pkg::VAL_W'(64'd0 - mag);
        r.saturated = sat;
        return 1;
    endfunction

    task automatic send_request(input cel_pkg::item_t it);
        cel_pkg::result_t r;
        int gap;
        // random gap ahead of roughly every third request
        if ($urandom_range(2) == 0)
        begin
            gap = $urandom_range(1, 5);
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        if (predict_item(it, r))
            expected_results.push_back(r);
    endtask

    task automatic send_fields(input logic f, input logic [16:0] p, input logic [16:0] t,
                               input logic l);
        cel_pkg::item_t it;
        it.func = f;
        it.prediction = p;
        it.target = t;
        it.last = l;
        send_request(it);
    endtask

    task automatic drain_and_settle();
        int guard;
        guard = 0;
        item_valid <= 1'b0;
        while (expected_results.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        // a non-last loss request may still be in flight
        repeat (120) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [cel_pkg::CFG_W-1:0] val);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= val;
        @(posedge clk);
        wr_en <= 1'b0;
        @(posedge clk);
        if (idx == cel_pkg::REG_EPSILON)
            eps_reg = cel_pkg::EPS_W'(val);
        else
            n_reg = val;
    endtask

    function automatic logic [16:0] rand_prob();
        case ($urandom_range(9))
            0: return 17'($urandom_range(3));
            1: return 17'(65536 - $urandom_range(3));
            2: return 17'($urandom_range(131071));
            default: return 17'($urandom_range(65536));
        endcase
    endfunction

    task automatic test_directed_loss();
        send_fields(cel_pkg::FUNC_LOSS, 17'd0, 17'd65536, 1'b0);
        send_fields(cel_pkg::FUNC_LOSS, 17'd65536, 17'd65536, 1'b0);
        send_fields(cel_pkg::FUNC_LOSS, 17'd32768, 17'd0, 1'b0);
        send_fields(cel_pkg::FUNC_LOSS, 17'd1, 17'd131071, 1'b1);
        send_fields(cel_pkg::FUNC_LOSS, 17'd131071, 17'd0, 1'b1);
        send_fields(cel_pkg::FUNC_LOSS, 17'd21845, 17'd43690, 1'b1);
        send_fields(cel_pkg::FUNC_LOSS, 17'd1, 17'd1, 1'b1);
    endtask

    task automatic test_directed_gradient();
        send_fields(cel_pkg::FUNC_GRAD, 17'd0, 17'd131071, 1'b1);
        send_fields(cel_pkg::FUNC_GRAD, 17'd1, 17'd65536, 1'b0);
        send_fields(cel_pkg::FUNC_GRAD, 17'd65536, 17'd65536, 1'b0);
        send_fields(cel_pkg::FUNC_GRAD, 17'd131071, 17'd1, 1'b1);
        send_fields(cel_pkg::FUNC_GRAD, 17'd43690, 17'd0, 1'b0);
    endtask

    task automatic test_loss_sum_saturation();
        // prediction at eps=1 with max target piles up fast but never near 2^48;
        // n=1 still leaves a large loss result
        for (int i = 0; i < 4; i++)
            send_fields(cel_pkg::FUNC_LOSS, 17'd0, 17'd131071, 1'b0);
        send_fields(cel_pkg::FUNC_LOSS, 17'd0, 17'd131071, 1'b1);
    endtask

    task automatic test_config_extremes();
        drain_and_settle();
        write_reg(cel_pkg::REG_EPSILON, 16'd32767);
        write_reg(cel_pkg::REG_BATCH, 16'd65535);
        send_fields(cel_pkg::FUNC_LOSS, 17'd0, 17'd65536, 1'b0);
        send_fields(cel_pkg::FUNC_LOSS, 17'd65536, 17'd65536, 1'b1);
        send_fields(cel_pkg::FUNC_GRAD, 17'd0, 17'd131071, 1'b0);
        drain_and_settle();
        write_reg(cel_pkg::REG_EPSILON, 16'd0);
        write_reg(cel_pkg::REG_BATCH, 16'd0);
        send_fields(cel_pkg::FUNC_GRAD, 17'd0, 17'd65536, 1'b0);
        send_fields(cel_pkg::FUNC_LOSS, 17'd0, 17'd65536, 1'b1);
        drain_and_settle();
        write_reg(cel_pkg::REG_EPSILON, 16'hFFFF);
        write_reg(cel_pkg::REG_BATCH, 16'd1);
        send_fields(cel_pkg::FUNC_GRAD, 17'd100, 17'd65536, 1'b0);
    endtask

    task automatic test_random_streams(input int count);
        int sent;
        int len;
        sent = 0;
        while (sent < count)
        begin
            if (sent % 90 == 0 && sent != 0)
            begin
                drain_and_settle();
                write_reg(cel_pkg::REG_EPSILON, cel_pkg::CFG_W'($urandom_range(4) == 0 ?
                          $urandom_range(65535) : $urandom_range(1, 2000)));
                write_reg(cel_pkg::REG_BATCH, cel_pkg::CFG_W'($urandom_range(4) == 0 ?
                          $urandom_range(65535) : $urandom_range(1, 64)));
            end
            if ($urandom_range(3) == 0)
            begin
                send_fields(cel_pkg::FUNC_GRAD, rand_prob(), rand_prob(), 1'($urandom));
                sent++;
            end
            else
            begin
                // short tensor of loss elements ending in last
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++)
                    send_fields(cel_pkg::FUNC_LOSS, rand_prob(),
                                ($urandom_range(4) == 0) ? 17'd0 : rand_prob(),
                                1'(i == len - 1));
                sent += len;
            end
        end
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        for (int i = 0; i < 8; i++)
            send_fields(cel_pkg::FUNC_GRAD, rand_prob(), rand_prob(), 1'b0);
        hold_off = 1'b0;
    endtask

    // receiver stall pattern plus the long hold-off
    initial
    begin
        int phase;
        result_stall = 1'b0;
        phase = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                result_stall <= 1'b1;
                repeat (600) @(posedge clk);
                result_stall <= 1'b0;
                wait (!hold_off);
            end
            else
            begin
                phase++;
                if ((phase / 200) % 3 == 0)
                    result_stall <= 1'b0;
                else
                    result_stall <= ($urandom_range(3) == 0);
            end
        end
    end

    // result checker
    initial
    begin
        cel_pkg::result_t exp_r;
        errors = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result value=%0d", result.value);
                    errors++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (result.kind !== exp_r.kind)
                    begin
                        $error("kind expected %0d actual %0d", exp_r.kind, result.kind);
                        errors++;
                    end
                    if (result.value !== exp_r.value)
                    begin
                        $error("value expected %0d actual %0d", exp_r.value, result.value);
                        errors++;
                    end
                    if (result.saturated !== exp_r.saturated)
                    begin
                        $error("saturated expected %0d actual %0d", exp_r.saturated,
                               result.saturated);
                        errors++;
                    end
                end
            end
        end
    end

    // watchdog on cycles with no request or result moving
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("cross_entropy_loss_and_gradient verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        int guard;
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        wr_en = 1'b0;
        wr_index = cel_pkg::REG_EPSILON;
        wr_data = '0;
        hold_off = 1'b0;
        eps_reg = 1;
        n_reg = 1;
        loss_acc = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_loss();
        test_directed_gradient();
        test_loss_sum_saturation();
        test_config_extremes();
        test_backpressure();
        test_random_streams(430);
        item_valid <= 1'b0;
        guard = 0;
        while (expected_results.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (150) @(posedge clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("cross_entropy_loss_and_gradient verification clean");
        else
            $display("cross_entropy_loss_and_gradient verification failed");
        $finish;
    end

endmodule

`default_nettype wire
